// ===== src/floppy_logic_state_sequencer_core_defines.svh =====
// Assertion macros used by the sequencer core RTL.
`ifndef FLOPPY_LOGIC_STATE_SEQUENCER_CORE_DEFINES_SVH
`define FLOPPY_LOGIC_STATE_SEQUENCER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("sequencer check failed");
`define ASSERT_RST(label, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("sequencer reset check failed");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_RST(label, prop)
`endif

`endif

// ===== src/fllss_pkg.sv =====
package fllss_pkg;

	localparam logic REQ_ACCESS = 1'b0;
	localparam logic REQ_TICK   = 1'b1;

	localparam logic [1:0] CFG_BIT_PERIOD = 2'd0;
	localparam logic [1:0] CFG_WP_MASK    = 2'd1;
	localparam logic [1:0] CFG_MOTOR_OFF  = 2'd2;

	localparam logic [7:0]  BIT_PERIOD_RST = 8'd32;
	localparam logic [20:0] MOTOR_OFF_RST  = 21'd2000000;
	localparam logic [8:0]  MIN_TIMING     = 9'd4;
	localparam logic [8:0]  CLOCK_STEP     = 9'd4;

	// switch_addr[2:1] when switch_addr[3] is set
	localparam logic [1:0] SW_MOTOR = 2'b00;
	localparam logic [1:0] SW_DRIVE = 2'b01;
	localparam logic [1:0] SW_LOAD  = 2'b10;
	localparam logic [1:0] SW_WRITE = 2'b11;

	localparam int MODE_WR = 0;
	localparam int MODE_LD = 1;
	localparam int MODE_QA = 2;
	localparam int MODE_RP = 3;

	localparam logic [1:0] ACT_NOP  = 2'd0;
	localparam logic [1:0] ACT_SHL  = 2'd1;
	localparam logic [1:0] ACT_SHR  = 2'd2;
	localparam logic [1:0] ACT_LOAD = 2'd3;

	typedef struct packed {
		logic       req_type;
		logic [3:0] switch_addr;
		logic       is_write;
		logic [7:0] write_data;
		logic       disk_bit;
		logic       random_bit;
	} lss_req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       bit_advance;
		logic       write_strobe;
		logic       strobe_bit;
		logic [7:0] quarter_track;
		logic       drive_sel;
		logic       motor_running;
	} lss_rsp_t;

	typedef struct packed {
		logic [7:0]  bit_period;
		logic [1:0]  write_protect_mask;
		logic [20:0] motor_off_ticks;
	} lss_cfg_t;

	typedef struct packed {
		logic [7:0]  data;
		logic [7:0]  latch;
		logic [3:0]  window;
		logic [3:0]  seq;
		logic [3:0]  mode;
		logic [8:0]  clk_acc;
		logic [3:0]  skip;
		logic        motor;
		logic        sel;
		logic [20:0] count;
		logic        pending;
	} lss_core_t;

	// indexed by {mode, state}
	localparam logic [7:0] SEQ_ROM [0:255] = '{
		8'h18, 8'h2D, 8'h38, 8'h48, 8'h58, 8'h68, 8'h78, 8'h88,
		8'h98, 8'h29, 8'hBD, 8'h59, 8'hD9, 8'h08, 8'hFD, 8'h4D,
		8'h18, 8'h28, 8'h39, 8'h48, 8'h58, 8'h68, 8'h78, 8'h08,
		8'h98, 8'hA8, 8'hB9, 8'hC8, 8'hD8, 8'hE8, 8'hF8, 8'h88,
		8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A,
		8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A,
		8'h18, 8'h28, 8'h3B, 8'h48, 8'h58, 8'h68, 8'h78, 8'h08,
		8'h98, 8'hA8, 8'hBB, 8'hC8, 8'hD8, 8'hE8, 8'hF8, 8'h88,
		8'h18, 8'h38, 8'h28, 8'h48, 8'h58, 8'h68, 8'h78, 8'h88,
		8'h98, 8'hA8, 8'hB8, 8'hC8, 8'hA0, 8'hE8, 8'hF8, 8'hE0,
		8'h18, 8'h28, 8'h39, 8'h48, 8'h58, 8'h68, 8'h78, 8'h88,
		8'h98, 8'hA8, 8'hB9, 8'hC8, 8'hD8, 8'hE8, 8'hF8, 8'h08,
		8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A,
		8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A,
		8'h18, 8'h28, 8'h3B, 8'h48, 8'h58, 8'h68, 8'h78, 8'h88,
		8'h98, 8'hA8, 8'hBB, 8'hC8, 8'hD8, 8'hE8, 8'hF8, 8'h08,
		8'h18, 8'h2D, 8'hD8, 8'hD8, 8'hD8, 8'hD8, 8'hD8, 8'hD8,
		8'hD8, 8'hD8, 8'hCD, 8'hD9, 8'hD9, 8'hD8, 8'hFD, 8'hDD,
		8'h18, 8'h28, 8'h39, 8'h48, 8'h58, 8'h68, 8'h78, 8'h08,
		8'h98, 8'hA8, 8'hB9, 8'hC8, 8'hD8, 8'hE8, 8'hF8, 8'h88,
		8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A,
		8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A,
		8'h18, 8'h28, 8'h3B, 8'h48, 8'h58, 8'h68, 8'h78, 8'h08,
		8'h98, 8'hA8, 8'hBB, 8'hC8, 8'hD8, 8'hE8, 8'hF8, 8'h88,
		8'h18, 8'h38, 8'h08, 8'h48, 8'hD8, 8'hD8, 8'hD8, 8'hD8,
		8'hD8, 8'hD8, 8'hD8, 8'hD8, 8'hD8, 8'hE8, 8'hF8, 8'hE0,
		8'h18, 8'h28, 8'h39, 8'h48, 8'h58, 8'h68, 8'h78, 8'h88,
		8'h98, 8'hA8, 8'hB9, 8'hC8, 8'hD8, 8'hE8, 8'hF8, 8'h08,
		8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A,
		8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A,
		8'h18, 8'h28, 8'h3B, 8'h48, 8'h58, 8'h68, 8'h78, 8'h88,
		8'h98, 8'hA8, 8'hBB, 8'hC8, 8'hD8, 8'hE8, 8'hF8, 8'h08
	};

endpackage

// ===== src/fllss_cfg.sv =====
module fllss_cfg
	import fllss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [20:0] cfg_data,
	output lss_cfg_t    cfg
);

	lss_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_period         <= BIT_PERIOD_RST;
			cfg_q.write_protect_mask <= 2'd0;
			cfg_q.motor_off_ticks    <= MOTOR_OFF_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BIT_PERIOD: cfg_q.bit_period <= cfg_data[7:0];
				CFG_WP_MASK:    cfg_q.write_protect_mask <= cfg_data[1:0];
				CFG_MOTOR_OFF:  cfg_q.motor_off_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== src/fllss_step.sv =====
module fllss_step
	import fllss_pkg::*;
#(
	parameter int TRACK_COUNT = 35,
	parameter int DRIVE_COUNT = 2
) (
	input  lss_req_t   req,
	input  lss_cfg_t   cfg,
	input  lss_core_t  core,
	input  logic [1:0] phase,
	input  logic [7:0] track,
	input  logic [7:0] alt_track,
	output lss_core_t  core_nx,
	output logic [1:0] phase_nx,
	output logic [7:0] track_nx,
	output lss_rsp_t   rsp
);

	localparam logic [8:0] TRACK_TOP = 9'(TRACK_COUNT * 4 - 1);

	logic       on;
	logic [1:0] pos;
	logic       run;
	logic [8:0] timing;
	logic [8:0] cc;
	logic [3:0] mode_v;
	logic [3:0] win;
	logic [7:0] cmd;
	logic [20:0] cnt;

	assign on  = req.switch_addr[0];
	assign pos = req.switch_addr[2:1];
	assign timing = (cfg.bit_period < MIN_TIMING[7:0]) ? MIN_TIMING : {1'b0, cfg.bit_period};

	always_comb begin
		core_nx  = core;
		phase_nx = phase;
		track_nx = track;
		rsp      = '0;
		mode_v   = core.mode;
		cc       = core.clk_acc;
		win      = core.window;
		cmd      = '0;
		cnt      = core.count;
		run      = (req.req_type == REQ_ACCESS) || core.motor;

		if (req.req_type == REQ_ACCESS) begin
			if (req.is_write) core_nx.latch = req.write_data;
			if (!req.switch_addr[3]) begin
				if (on) begin
					if ((phase - 2'd1) == pos) begin
						track_nx = (track < 8'd2) ? 8'd0 : track - 8'd2;
					end else if ((phase + 2'd1) == pos) begin
						track_nx = (({1'b0, track} + 9'd2) > TRACK_TOP) ? TRACK_TOP[7:0]
							: track + 8'd2;
					end
					phase_nx = pos;
				end
			end else begin
				unique case (pos)
					SW_MOTOR: begin
						if (on) begin
							core_nx.pending = 1'b0;
							core_nx.count   = '0;
							core_nx.motor   = 1'b1;
						end else if (!core.pending) begin
							if (cfg.motor_off_ticks == '0) begin
								core_nx.motor = 1'b0;
							end else begin
								core_nx.pending = 1'b1;
								core_nx.count   = cfg.motor_off_ticks;
							end
						end
					end
					SW_DRIVE: begin
						if (DRIVE_COUNT > 1 || !on) core_nx.sel = on;
					end
					SW_LOAD:  core_nx.mode[MODE_LD] = on;
					SW_WRITE: core_nx.mode[MODE_WR] = on;
					default: ;
				endcase
			end
		end

		if (run) begin
			if (core_nx.skip != 4'd0) begin
				core_nx.skip = core_nx.skip - 4'd1;
			end else begin
				mode_v = core_nx.mode;
				mode_v[MODE_QA] = core_nx.data[7];
				cc = core_nx.clk_acc + CLOCK_STEP;
				if (cc >= timing) begin
					cc = cc - timing;
					rsp.bit_advance = 1'b1;
					if (!mode_v[MODE_WR]) begin
						win = {core_nx.window[2:0], req.disk_bit};
						core_nx.window = win;
						mode_v[MODE_RP] = (win == 4'd0) ? req.random_bit : win[1];
					end else begin
						rsp.write_strobe = 1'b1;
						rsp.strobe_bit   = core_nx.data[7];
					end
				end
				core_nx.clk_acc = cc;
				cmd = SEQ_ROM[{mode_v, core_nx.seq}];
				if (cmd[3]) begin
					unique case (cmd[1:0])
						ACT_NOP:  ;
						ACT_SHL:  core_nx.data = {core_nx.data[6:0], cmd[2]};
						ACT_SHR:  core_nx.data = {cfg.write_protect_mask[core_nx.sel],
							core_nx.data[7:1]};
						ACT_LOAD: core_nx.data = core_nx.latch;
						default: ;
					endcase
				end else begin
					core_nx.data = '0;
				end
				core_nx.seq = cmd[7:4];
				mode_v[MODE_RP] = 1'b0;
				core_nx.mode = mode_v;
			end
		end

		if (req.req_type == REQ_ACCESS) begin
			if (core_nx.skip != 4'hF) core_nx.skip = core_nx.skip + 4'd1;
			rsp.read_data = on ? req.write_data : core_nx.data;
		end else begin
			if (core.pending) begin
				if (cnt != '0) cnt = cnt - 21'd1;
				core_nx.count = cnt;
				if (cnt == '0) begin
					core_nx.pending = 1'b0;
					core_nx.motor   = 1'b0;
				end
			end
			rsp.read_data = core_nx.data;
		end

		rsp.quarter_track = (core_nx.sel == core.sel) ? track_nx : alt_track;
		rsp.drive_sel     = core_nx.sel;
		rsp.motor_running = core_nx.motor;
	end

endmodule

// ===== src/floppy_logic_state_sequencer_core.sv =====
// Floppy controller logic state sequencer.
// Request channel (req_valid, req_stall, req_data): one beat is either a
// soft-switch bus access or one 0.5 us sequencer tick. Response channel
// (rsp_valid, rsp_stall, rsp_data): exactly one beat per request beat, in order.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): index 0
// bit period, 1 write protect mask, 2 motor off delay; write only while idle.
// A request accepted into the staged request register passes through the
// step logic into the response register. Throughput: one request per cycle
// while rsp_stall does not hold the response, set by the ROM lookup and
// state update loop.
// The response register frees as its beat leaves, so a request is taken in
// the same cycle a waiting response is taken. While rsp_stall holds the
// response, the staged request waits and req_stall rises.
// Reset clears the sequencer, drive and motor state and loads the default
// configuration; no clearing pass is needed.
`include "floppy_logic_state_sequencer_core_defines.svh"

module floppy_logic_state_sequencer_core
	import fllss_pkg::*;
#(
	parameter int TRACK_COUNT = 35,
	parameter int DRIVE_COUNT = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  lss_req_t    req_data,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output lss_rsp_t    rsp_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [20:0] cfg_data
);

	localparam logic [7:0] TRACK_TOP = 8'(TRACK_COUNT * 4 - 1);

	lss_cfg_t   cfg;
	lss_req_t   req_s1;
	logic       valid_s1;
	logic       advance;
	lss_core_t  core_q;
	lss_core_t  core_nx;
	logic [1:0] phase_q [DRIVE_COUNT];
	logic [7:0] track_q [DRIVE_COUNT];
	logic [1:0] cur_phase;
	logic [7:0] cur_track;
	logic [7:0] alt_track;
	logic [1:0] phase_nx;
	logic [7:0] track_nx;
	lss_rsp_t   rsp_nx;
	logic       rsp_valid_q;
	lss_rsp_t   rsp_q;

	fllss_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fllss_step #(
		.TRACK_COUNT (TRACK_COUNT),
		.DRIVE_COUNT (DRIVE_COUNT)
	) u_step (
		.req       (req_s1),
		.cfg       (cfg),
		.core      (core_q),
		.phase     (cur_phase),
		.track     (cur_track),
		.alt_track (alt_track),
		.core_nx   (core_nx),
		.phase_nx  (phase_nx),
		.track_nx  (track_nx),
		.rsp       (rsp_nx)
	);

	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	if (DRIVE_COUNT > 1) begin : g_two
		assign cur_phase = phase_q[core_q.sel];
		assign cur_track = track_q[core_q.sel];
		assign alt_track = track_q[!core_q.sel];
	end else begin : g_one
		assign cur_phase = phase_q[0];
		assign cur_track = track_q[0];
		assign alt_track = track_q[0];
	end

	for (genvar d = 0; d < DRIVE_COUNT; d++) begin : g_drive
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				phase_q[d] <= '0;
				track_q[d] <= '0;
			end else if (advance && (core_q.sel == 1'(d))) begin
				phase_q[d] <= phase_nx;
				track_q[d] <= track_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) req_s1 <= req_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			core_q <= '0;
		end else if (advance) begin
			core_q <= core_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) rsp_q <= rsp_nx;
	end

	`ASSERT_CLK(a_track_range, cur_track <= TRACK_TOP)
	`ASSERT_CLK(a_advance_fills, advance |=> rsp_valid_q)
	`ASSERT_CLK(a_strobe_on_cell, rsp_valid_q |-> (!rsp_q.write_strobe || rsp_q.bit_advance))
	`ASSERT_CLK(a_wbit_needs_strobe, rsp_valid_q && !rsp_q.write_strobe |-> !rsp_q.strobe_bit)
	`ASSERT_RST(a_idle_after_reset, !arst_n |=> !rsp_valid_q && !valid_s1)

endmodule
